>>> src/b64sd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64sd_pkg;

    // Symbol codes from the character classifier. Values below 64 are data.
    localparam logic [6:0] SYM_PAD  = 7'd64;
    localparam logic [6:0] SYM_SKIP = 7'd65;

    // Tuple phase. The eighth code is never entered and acts as an error.
    typedef enum logic [2:0] {
        PH_0     = 3'd0,
        PH_1     = 3'd1,
        PH_2     = 3'd2,
        PH_3     = 3'd3,
        PH_PAD1  = 3'd4,
        PH_DONE  = 3'd5,
        PH_ERR   = 3'd6
    } t_phase;

    // Maps one raw character to its 6-bit value, the pad code or the skip code.
    function automatic logic [6:0] classify(input logic [7:0] c, input logic url);
        logic [6:0] sym;
        sym = SYM_SKIP;
        if (c inside {["A":"Z"]}) begin
            sym = 7'(c - 8'h41);
        end else if (c inside {["a":"z"]}) begin
            sym = 7'(c - 8'h61 + 8'd26);
        end else if (c inside {["0":"9"]}) begin
            sym = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h3d) begin
            sym = SYM_PAD;
        end else if (url && c == 8'h2d) begin
            sym = 7'd62;
        end else if (url && c == 8'h5f) begin
            sym = 7'd63;
        end else if (!url && c == 8'h2b) begin
            sym = 7'd62;
        end else if (!url && c == 8'h2f) begin
            sym = 7'd63;
        end
        return sym;
    endfunction

endpackage

`default_nettype wire

>>> src/base64_stream_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming Base64 decoder (standard or URL-safe alphabet, chosen by the
// one-bit configuration register). It takes one encoded character per input
// word and returns decoded bytes on the output channel, followed by one
// status word when a character is marked as the end of a message. A
// character is classified and folded into the tuple state in the cycle it is
// accepted, and all result words it causes (zero to four) are captured at
// once into a small result register. That register is then drained one word
// per cycle while the output is not stalled. A new character is taken in the
// same cycle the last pending result word leaves, so the block sustains one
// character per cycle whenever the output is not stalled and each character
// causes at most one result word; a character that completes a tuple (three
// bytes) or also ends a message holds the input until all of its result words
// have left. Characters outside the alphabet are dropped without producing
// data bytes. The status word carries out_byte zero and flags a
// malformed-padding error seen since the start of the message. The
// configuration register must only be written while the block is idle.
module base64_stream_decoder_core
    import b64sd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration: alphabet select, 1 picks the URL-safe alphabet
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_data,
    // Input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_end_of_message,
    // Output channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_is_status,
    output logic            o_decode_error,
    output logic            o_last_of_run
);

    logic         r_url_alpha;
    t_phase       r_phase, n_phase;
    logic [17:0]  r_acc, n_acc;

    // Result register: up to three data bytes, then an optional status word.
    logic         r_valid, n_valid;
    logic [7:0]   r_byte0, r_byte1, r_byte2;
    logic [1:0]   r_ndata;
    logic         r_status;
    logic         r_err;
    logic [1:0]   r_pos, n_pos;

    logic         in_accept;
    logic         out_take;
    logic         out_last;
    logic [6:0]   sym;
    logic         is_data;
    logic [5:0]   dval;
    logic [23:0]  full_word;
    t_phase       tuple_phase;
    logic [1:0]   b_ndata;
    logic [7:0]   b_byte0, b_byte1, b_byte2;
    logic         b_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url_alpha <= 1'b0;
        end else if (i_cfg_we) begin
            r_url_alpha <= i_cfg_data;
        end
    end

    assign sym       = classify(i_in_char, r_url_alpha);
    assign is_data   = (sym < SYM_PAD);
    assign dval      = sym[5:0];
    assign full_word = {r_acc, dval};

    // Next tuple state for the accepted character.
    always_comb begin
        tuple_phase = r_phase;
        n_acc       = r_acc;
        if (sym != SYM_SKIP) begin
            case (r_phase)
                PH_0: begin
                    if (is_data) begin
                        n_acc       = {12'd0, dval};
                        tuple_phase = PH_1;
                    end else begin
                        tuple_phase = PH_ERR;
                    end
                end
                PH_1: begin
                    if (is_data) begin
                        n_acc       = {r_acc[11:0], dval};
                        tuple_phase = PH_2;
                    end else begin
                        tuple_phase = PH_ERR;
                    end
                end
                PH_2: begin
                    if (is_data) begin
                        n_acc       = {r_acc[11:0], dval};
                        tuple_phase = PH_3;
                    end else begin
                        tuple_phase = PH_PAD1;
                    end
                end
                PH_3: begin
                    if (is_data) begin
                        n_acc       = 18'd0;
                        tuple_phase = PH_0;
                    end else begin
                        tuple_phase = PH_DONE;
                    end
                end
                PH_PAD1: tuple_phase = is_data ? PH_ERR : PH_DONE;
                PH_DONE: tuple_phase = PH_ERR;
                default: tuple_phase = r_phase;
            endcase
        end
        // Error is judged on the phase after this character's update.
        b_err   = (tuple_phase == PH_ERR) || (tuple_phase == t_phase'(3'd7));
        n_phase = tuple_phase;
        if (i_end_of_message) begin
            n_phase = PH_0;
            n_acc   = 18'd0;
        end
    end

    // Data bytes released by the accepted character.
    always_comb begin
        b_ndata = 2'd0;
        b_byte0 = full_word[23:16];
        b_byte1 = full_word[15:8];
        b_byte2 = full_word[7:0];
        if (sym != SYM_SKIP) begin
            case (r_phase)
                PH_2: begin
                    if (!is_data) begin
                        b_ndata = 2'd1;
                        b_byte0 = r_acc[11:4];
                    end
                end
                PH_3: begin
                    if (is_data) begin
                        b_ndata = 2'd3;
                    end else begin
                        b_ndata = 2'd2;
                        b_byte0 = r_acc[17:10];
                        b_byte1 = r_acc[9:2];
                    end
                end
                default: b_ndata = 2'd0;
            endcase
        end
    end

    // Drain control. The last pending word leaving frees the register.
    assign out_last   = r_status ? (r_pos == r_ndata) : (r_pos == r_ndata - 2'd1);
    assign out_take   = r_valid && !i_out_stall;
    assign o_in_stall = r_valid && !(out_take && out_last);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        n_pos   = r_pos;
        if (out_take) begin
            if (out_last) begin
                n_valid = 1'b0;
            end else begin
                n_pos = r_pos + 2'd1;
            end
        end
        if (in_accept) begin
            n_valid = (b_ndata != 2'd0) || i_end_of_message;
            n_pos   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_acc   <= 18'd0;
            r_valid <= 1'b0;
            r_pos   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
            if (in_accept) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte0  <= b_byte0;
            r_byte1  <= b_byte1;
            r_byte2  <= b_byte2;
            r_ndata  <= b_ndata;
            r_status <= i_end_of_message;
            r_err    <= b_err;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_is_status    = (r_pos == r_ndata);
    assign o_decode_error = o_is_status && r_err;
    assign o_last_of_run  = out_last;

    always_comb begin
        if (o_is_status) begin
            o_out_byte = 8'd0;
        end else begin
            case (r_pos)
                2'd0:    o_out_byte = r_byte0;
                2'd1:    o_out_byte = r_byte1;
                default: o_out_byte = r_byte2;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/b64sd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module b64sd_checker
    import b64sd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_cfg_we,
    input wire logic       i_cfg_data,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [7:0] i_in_char,
    input wire logic       i_end_of_message,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_is_status,
    input wire logic       o_decode_error,
    input wire logic       o_last_of_run
);

    // A stalled result word holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_is_status) && $stable(o_last_of_run))
        else $error("result word changed while stalled");

    // The status word always closes the run of its character.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_status |-> o_last_of_run && (o_out_byte == 8'd0))
        else $error("status word not last or carries a byte");

    // The error flag only appears on status words.
    a_err_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_decode_error |-> o_is_status)
        else $error("error flag on a data word");

    // The input only waits on pending result words.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

    // After the last word of a run leaves, no word of that run follows
    // unless a new character was accepted alongside it.
    a_run_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last_of_run && !(i_in_valid && !o_in_stall)
            |=> !o_out_valid)
        else $error("result word after end of run");

endmodule

bind base64_stream_decoder_core b64sd_checker u_b64sd_checker (.*);

`default_nettype wire
